// ===== rtl/pps_pkg.sv =====
package pps_pkg;

    localparam int GAIN_FRACTION_BITS = 24;

    localparam int S_TDATA_W   = 88;
    localparam int M_TDATA_W   = 56;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam int TERM_LIMIT_BITS = 50;
    localparam int ACC_W           = TERM_LIMIT_BITS + 3;

    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_P   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_I   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_D   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BOUND    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DEADBAND = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_PERIOD   = 3'd5;

    localparam logic [31:0] RST_GAIN_P   = 32'd6710886;
    localparam logic [31:0] RST_GAIN_I   = 32'd8389;
    localparam logic [31:0] RST_GAIN_D   = 32'd41943040;
    localparam logic [30:0] RST_BOUND    = 31'd50000000;
    localparam logic [15:0] RST_DEADBAND = 16'd20;
    localparam logic [19:0] RST_PERIOD   = 20'd500000;

    typedef struct packed {
        logic [31:0] gain_p;
        logic [31:0] gain_i;
        logic [31:0] gain_d;
        logic [30:0] bound;
        logic [15:0] deadband;
        logic [19:0] period;
    } cfg_t;

    typedef enum logic [1:0] {
        MUL_P,
        MUL_I,
        MUL_D,
        MUL_DUTY
    } mul_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_PREP,
        ST_ABS,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_TERM_D,
        ST_ACC_D,
        ST_CLAMP,
        ST_DUTY,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic     capture;
        logic     diff;
        logic     prep;
        logic     absval;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     term_en;
        logic     acc_en;
        logic     clamp;
        logic     int_clear;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic halt;
        logic blocked;
        logic out_free;
    } status_t;

endpackage

// ===== rtl/pps_cfg.sv =====
module pps_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [pps_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pps_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output pps_pkg::cfg_t                   cfg
);

    pps_pkg::cfg_t cfg_reg;
    pps_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                pps_pkg::REG_GAIN_P:   cfg_next.gain_p   = cfg_wdata;
                pps_pkg::REG_GAIN_I:   cfg_next.gain_i   = cfg_wdata;
                pps_pkg::REG_GAIN_D:   cfg_next.gain_d   = cfg_wdata;
                pps_pkg::REG_BOUND:    cfg_next.bound    = cfg_wdata[30:0];
                pps_pkg::REG_DEADBAND: cfg_next.deadband = cfg_wdata[15:0];
                pps_pkg::REG_PERIOD:   cfg_next.period   = cfg_wdata[19:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain_p   <= pps_pkg::RST_GAIN_P;
            cfg_reg.gain_i   <= pps_pkg::RST_GAIN_I;
            cfg_reg.gain_d   <= pps_pkg::RST_GAIN_D;
            cfg_reg.bound    <= pps_pkg::RST_BOUND;
            cfg_reg.deadband <= pps_pkg::RST_DEADBAND;
            cfg_reg.period   <= pps_pkg::RST_PERIOD;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/pps_ctrl.sv =====
module pps_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  pps_pkg::status_t   status,
    output pps_pkg::cmd_t      cmd
);

    pps_pkg::state_t state_reg;
    pps_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pps_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd         = '0;
        cmd.mul_sel = pps_pkg::MUL_P;
        s_tready    = 1'b0;
        state_next  = state_reg;
        unique case (state_reg)
            pps_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = pps_pkg::ST_DIFF;
                end
            end
            pps_pkg::ST_DIFF: begin
                cmd.diff   = 1'b1;
                state_next = pps_pkg::ST_PREP;
            end
            pps_pkg::ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = pps_pkg::ST_ABS;
            end
            pps_pkg::ST_ABS: begin
                if (status.halt) begin
                    cmd.int_clear = 1'b1;
                    state_next    = pps_pkg::ST_OUT;
                end else if (status.blocked) begin
                    state_next = pps_pkg::ST_OUT;
                end else begin
                    cmd.absval = 1'b1;
                    state_next = pps_pkg::ST_MUL_P;
                end
            end
            pps_pkg::ST_MUL_P: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = pps_pkg::MUL_P;
                state_next  = pps_pkg::ST_MUL_I;
            end
            pps_pkg::ST_MUL_I: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = pps_pkg::MUL_I;
                cmd.term_en = 1'b1;
                state_next  = pps_pkg::ST_MUL_D;
            end
            pps_pkg::ST_MUL_D: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = pps_pkg::MUL_D;
                cmd.term_en = 1'b1;
                cmd.acc_en  = 1'b1;
                state_next  = pps_pkg::ST_TERM_D;
            end
            pps_pkg::ST_TERM_D: begin
                cmd.term_en = 1'b1;
                cmd.acc_en  = 1'b1;
                state_next  = pps_pkg::ST_ACC_D;
            end
            pps_pkg::ST_ACC_D: begin
                cmd.acc_en = 1'b1;
                state_next = pps_pkg::ST_CLAMP;
            end
            pps_pkg::ST_CLAMP: begin
                cmd.clamp  = 1'b1;
                state_next = pps_pkg::ST_DUTY;
            end
            pps_pkg::ST_DUTY: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = pps_pkg::MUL_DUTY;
                state_next  = pps_pkg::ST_OUT;
            end
            pps_pkg::ST_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = pps_pkg::ST_IDLE;
                end
            end
            default: state_next = pps_pkg::ST_IDLE;
        endcase
    end

endmodule

// ===== rtl/pps_datapath.sv =====
module pps_datapath #(
    parameter int GAIN_FRACTION_BITS = pps_pkg::GAIN_FRACTION_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [pps_pkg::S_TDATA_W-1:0] s_tdata,
    input  pps_pkg::cfg_t                 cfg,
    input  pps_pkg::cmd_t                 cmd,
    output pps_pkg::status_t              status,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pps_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int F     = GAIN_FRACTION_BITS;
    localparam int ACC_W = pps_pkg::ACC_W;
    localparam logic signed [ACC_W-1:0] EFFORT_ONE = ACC_W'(64'd1 << F);
    localparam logic [63:0] TERM_LIMIT = 64'd1 << pps_pkg::TERM_LIMIT_BITS;

    function automatic logic signed [31:0] clamp_integ(input logic signed [33:0] x,
                                                      input logic [30:0] bound);
        logic signed [33:0] pb;
        logic signed [33:0] nb;
        logic signed [33:0] r;
        pb = $signed({3'b000, bound});
        nb = -pb;
        if (x > pb) begin
            r = pb;
        end else if (x < nb) begin
            r = nb;
        end else begin
            r = x;
        end
        return r[31:0];
    endfunction

    logic signed [31:0] pos_reg;
    logic signed [31:0] tpos_reg;
    logic signed [15:0] tvel_reg;
    logic               lim_l_reg;
    logic               lim_r_reg;
    logic               run_reg;

    logic signed [31:0] prev_reg;
    logic signed [31:0] integral_reg;

    logic signed [31:0] vel_reg;
    logic signed [32:0] err_reg;
    logic signed [32:0] verr_reg;
    logic signed [31:0] integ_reg;
    logic               blocked_reg;

    logic [31:0] err_mag_reg;
    logic        err_neg_reg;
    logic [31:0] verr_mag_reg;
    logic        verr_neg_reg;
    logic [31:0] integ_mag_reg;
    logic        integ_neg_reg;

    logic [63:0]              prod_reg;
    logic                     prod_neg_reg;
    logic signed [ACC_W-1:0]  term_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    logic [F:0] umag_reg;
    logic       dir_reg;
    logic       sat_reg;

    logic                        m_tvalid_reg;
    logic [pps_pkg::M_TDATA_W-1:0] m_tdata_reg;

    logic signed [32:0] vel_diff;
    logic signed [31:0] vel_sat;
    logic signed [32:0] err_next;
    logic signed [32:0] verr_next;
    logic signed [33:0] isum;
    logic signed [32:0] err_abs;
    logic signed [32:0] verr_abs;
    logic signed [31:0] integ_abs;
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic               mul_neg;
    logic [50:0]        term_mag;
    logic signed [ACC_W-1:0] term_next;
    logic               over_pos;
    logic               over_neg;
    logic signed [33:0] isub;
    logic signed [31:0] integ_sat;
    logic               in_deadband;
    logic signed [ACC_W-1:0] acc_abs;
    logic [19:0]        duty;

    assign vel_diff = {pos_reg[31], pos_reg} - {prev_reg[31], prev_reg};
    always_comb begin
        if (vel_diff[32] != vel_diff[31]) begin
            vel_sat = vel_diff[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            vel_sat = vel_diff[31:0];
        end
    end
    assign err_next  = {tpos_reg[31], tpos_reg} - {pos_reg[31], pos_reg};
    assign verr_next = {{17{tvel_reg[15]}}, tvel_reg} - {vel_reg[31], vel_reg};
    assign isum      = {{2{integral_reg[31]}}, integral_reg} + {err_reg[32], err_reg};

    assign err_abs   = err_reg[32] ? -err_reg : err_reg;
    assign verr_abs  = verr_reg[32] ? -verr_reg : verr_reg;
    assign integ_abs = integ_reg[31] ? -integ_reg : integ_reg;

    always_comb begin
        case (cmd.mul_sel)
            pps_pkg::MUL_P: begin
                mul_a   = cfg.gain_p;
                mul_b   = err_mag_reg;
                mul_neg = err_neg_reg;
            end
            pps_pkg::MUL_I: begin
                mul_a   = cfg.gain_i;
                mul_b   = integ_mag_reg;
                mul_neg = integ_neg_reg;
            end
            pps_pkg::MUL_D: begin
                mul_a   = cfg.gain_d;
                mul_b   = verr_mag_reg;
                mul_neg = verr_neg_reg;
            end
            default: begin
                mul_a   = 32'(cfg.period);
                mul_b   = 32'(umag_reg);
                mul_neg = 1'b0;
            end
        endcase
    end

    assign term_mag  = (prod_reg > TERM_LIMIT) ? TERM_LIMIT[50:0] : prod_reg[50:0];
    assign term_next = prod_neg_reg ? -$signed({2'b00, term_mag}) : $signed({2'b00, term_mag});

    assign over_pos    = acc_reg > EFFORT_ONE;
    assign over_neg    = acc_reg < -EFFORT_ONE;
    assign isub        = {{2{integ_reg[31]}}, integ_reg} - {err_reg[32], err_reg};
    assign integ_sat   = clamp_integ(isub, cfg.bound);
    assign in_deadband = (err_mag_reg < 32'(cfg.deadband)) && (tvel_reg == 16'sd0);
    assign acc_abs     = acc_reg[ACC_W-1] ? -acc_reg : acc_reg;

    assign duty = prod_reg[F+19:F];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg     <= '0;
            integral_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.diff) begin
                prev_reg <= pos_reg;
            end
            if (cmd.int_clear) begin
                integral_reg <= '0;
            end else if (cmd.clamp) begin
                if (in_deadband) begin
                    integral_reg <= '0;
                end else if (over_pos || over_neg) begin
                    integral_reg <= integ_sat;
                end else begin
                    integral_reg <= integ_reg;
                end
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            pos_reg   <= s_tdata[31:0];
            tpos_reg  <= s_tdata[63:32];
            tvel_reg  <= s_tdata[79:64];
            lim_l_reg <= s_tdata[80];
            lim_r_reg <= s_tdata[81];
            run_reg   <= s_tdata[82];
        end
        if (cmd.diff) begin
            vel_reg <= vel_sat;
            err_reg <= err_next;
        end
        if (cmd.prep) begin
            verr_reg    <= verr_next;
            integ_reg   <= clamp_integ(isum, cfg.bound);
            blocked_reg <= (lim_l_reg && err_reg[32]) ||
                           (lim_r_reg && !err_reg[32] && (err_reg != 33'sd0));
        end
        if (cmd.absval) begin
            err_mag_reg   <= err_abs[31:0];
            err_neg_reg   <= err_reg[32];
            verr_mag_reg  <= verr_abs[31:0];
            verr_neg_reg  <= verr_reg[32];
            integ_mag_reg <= integ_abs;
            integ_neg_reg <= integ_reg[31];
            acc_reg       <= '0;
        end else if (cmd.acc_en) begin
            acc_reg <= acc_reg + term_reg;
        end
        if (cmd.mul_en) begin
            prod_reg     <= mul_a * mul_b;
            prod_neg_reg <= mul_neg;
        end
        if (cmd.term_en) begin
            term_reg <= term_next;
        end
        if (cmd.clamp) begin
            sat_reg <= over_pos || over_neg;
            if (in_deadband) begin
                umag_reg <= '0;
                dir_reg  <= 1'b1;
            end else if (over_pos || over_neg) begin
                umag_reg <= EFFORT_ONE[F:0];
                dir_reg  <= over_pos;
            end else begin
                umag_reg <= acc_abs[F:0];
                dir_reg  <= !acc_reg[ACC_W-1];
            end
        end
        if (cmd.out_load) begin
            m_tdata_reg[55:24] <= vel_reg;
            if (!run_reg) begin
                m_tdata_reg[23:0] <= {1'b0, 1'b0, 1'b0, 20'd0, 1'b1};
            end else if (blocked_reg) begin
                m_tdata_reg[23:0] <= {1'b0, 1'b1, 1'b0, 20'd0, 1'b1};
            end else begin
                m_tdata_reg[23:0] <= {sat_reg, 1'b0, 1'b1, duty, dir_reg};
            end
        end
    end

    assign status.halt     = !run_reg;
    assign status.blocked  = blocked_reg;
    assign status.out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== rtl/pid_position_servo_top.sv =====
// Position servo with PID control, anti-windup, deadband and end-switch stop. Each input beat
// is one control tick; each tick returns exactly one result beat. A running tick passes from
// IDLE through DIFF, PREP, ABS, MUL_P, MUL_I, MUL_D, TERM_D, ACC_D, CLAMP and DUTY to OUT,
// where it is loaded into the result register; a tick that is stopped (run low) or blocked by an
// end switch goes from ABS straight to OUT. One 32x32 multiplier is shared in turn by the
// proportional, integral and derivative terms and the duty scaling. The next tick is accepted
// as soon as the previous one has reached the result register, even if that beat has not been
// taken yet; a result beat that is still held stalls the next tick in its last stage.
// Configuration registers may be written only while no tick is in flight.
module pid_position_servo_top #(
    parameter int GAIN_FRACTION_BITS = pps_pkg::GAIN_FRACTION_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // position_count[31:0], target_position[63:32], target_velocity[79:64],
    // limit_left[80], limit_right[81], run[82], zero[87:83]
    input  logic [pps_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // drive_direction[0], duty[20:1], drive_enable[21], limit_stop[22],
    // effort_saturated[23], measured_velocity[55:24]
    output logic [pps_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            cfg_we,
    input  logic [pps_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pps_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    pps_pkg::cfg_t    cfg;
    pps_pkg::cmd_t    cmd;
    pps_pkg::status_t status;

    pps_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pps_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pps_datapath #(
        .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cfg      (cfg),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
